>>> rtl/pcs_pkg.sv
package pcs_pkg;

	localparam int COUNT_BITS  = 24;
	localparam int BIN_COUNT   = 256;
	localparam int BIN_BITS    = 8;
	localparam int PIX_BITS    = 8;
	localparam int MARGIN_BITS = 16;
	localparam int LIMIT_BITS  = COUNT_BITS + MARGIN_BITS;
	localparam int SUM_BITS    = COUNT_BITS + BIN_BITS;
	localparam int STEP_BITS   = BIN_BITS + 1;
	localparam int NUM_BITS    = 16;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_BITS  = RECIP_SHIFT + 1;
	localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;
	localparam int QUO_BITS    = PROD_BITS - RECIP_SHIFT;

	localparam logic [PIX_BITS-1:0]    PIX_MAX   = '1;
	localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;
	localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 16'd655;

	localparam logic CMD_HIST = 1'b0;
	localparam logic CMD_MAP  = 1'b1;

	localparam logic KIND_BOUNDS = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	localparam logic [1:0] REG_LOW_MARGIN  = 2'd0;
	localparam logic [1:0] REG_HIGH_MARGIN = 2'd1;

	typedef struct packed {
		logic                cmd;
		logic [PIX_BITS-1:0] pixel;
		logic                last;
	} in_item_t;

	typedef struct packed {
		logic                result_kind;
		logic [PIX_BITS-1:0] mapped_pixel;
		logic [PIX_BITS-1:0] low_bound;
		logic [PIX_BITS-1:0] high_bound;
		logic                pass_end;
	} out_item_t;

	typedef enum logic [2:0] {
		SR_IDLE,
		SR_WRITE,
		SR_MUL,
		SR_RD,
		SR_ADD,
		SR_DONE
	} srch_state_t;

	typedef logic [RECIP_BITS-1:0] recip_tab_t [BIN_COUNT];

	// ceil(2^24 / d) by long division, elaboration only
	function automatic recip_tab_t build_recip();
		recip_tab_t              tab;
		logic [RECIP_BITS:0]     num;
		logic [RECIP_BITS:0]     quo;
		logic [BIN_BITS+1:0]     rem;
		logic [BIN_BITS+1:0]     dv;
		tab[0] = '0;
		for (int d = 1; d < BIN_COUNT; d++) begin
			dv  = (BIN_BITS+2)'(d);
			num = (RECIP_BITS+1)'((1 << RECIP_SHIFT) + d - 1);
			quo = '0;
			rem = '0;
			for (int i = RECIP_BITS; i >= 0; i--) begin
				rem = {rem[BIN_BITS:0], num[i]};
				if (rem >= dv) begin
					rem    = rem - dv;
					quo[i] = 1'b1;
				end
			end
			tab[d] = quo[RECIP_BITS-1:0];
		end
		return tab;
	endfunction

	localparam recip_tab_t RECIP = build_recip();

endpackage

>>> rtl/pcs_hist.sv
module pcs_hist (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           upd_v,
	input  logic [pcs_pkg::BIN_BITS-1:0]   upd_bin,
	input  logic                           clear,
	input  logic                           srch_rd,
	input  logic [pcs_pkg::BIN_BITS-1:0]   srch_addr,
	output logic [pcs_pkg::COUNT_BITS-1:0] rd_count
);
	import pcs_pkg::*;

	logic [COUNT_BITS-1:0] mem [BIN_COUNT];
	logic [BIN_COUNT-1:0]  valid_q;
	logic [COUNT_BITS-1:0] rd_data_s1;
	logic                  rd_vld_s1;
	logic                  upd_s1;
	logic [BIN_BITS-1:0]   bin_s1;
	logic                  wr_v_q;
	logic [BIN_BITS-1:0]   wr_addr_q;
	logic [COUNT_BITS-1:0] wr_data_q;
	logic [BIN_BITS-1:0]   rd_addr;
	logic                  rd_en;
	logic [COUNT_BITS-1:0] old_cnt;
	logic [COUNT_BITS-1:0] new_cnt;
	logic                  wr_en;

	assign rd_addr = upd_v ? upd_bin : srch_addr;
	assign rd_en   = upd_v | srch_rd;
	assign wr_en   = upd_s1 & ~clear;

	// forward the bin written at the same edge as this read
	always_comb begin
		if (wr_v_q && wr_addr_q == bin_s1) begin
			old_cnt = wr_data_q;
		end else if (rd_vld_s1) begin
			old_cnt = rd_data_s1;
		end else begin
			old_cnt = '0;
		end
		new_cnt = (old_cnt == COUNT_MAX) ? COUNT_MAX : old_cnt + 1'b1;
	end

	assign rd_count = rd_vld_s1 ? rd_data_s1 : '0;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_vld_s1  <= valid_q[rd_addr];
		end
		if (wr_en) begin
			mem[bin_s1] <= new_cnt;
		end
	end

	always_ff @(posedge clk) begin
		bin_s1    <= upd_bin;
		wr_addr_q <= bin_s1;
		wr_data_q <= new_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1  <= 1'b0;
			wr_v_q  <= 1'b0;
			valid_q <= '0;
		end else begin
			upd_s1 <= upd_v;
			wr_v_q <= wr_en;
			if (clear) begin
				valid_q <= '0;
			end else if (upd_s1) begin
				valid_q[bin_s1] <= 1'b1;
			end
		end
	end

endmodule

>>> rtl/pcs_search.sv
module pcs_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            ack,
	input  logic [pcs_pkg::COUNT_BITS-1:0]  count,
	input  logic [pcs_pkg::MARGIN_BITS-1:0] low_margin,
	input  logic [pcs_pkg::MARGIN_BITS-1:0] high_margin,
	input  logic [pcs_pkg::COUNT_BITS-1:0]  rd_count,
	output logic                            rd_en,
	output logic [pcs_pkg::BIN_BITS-1:0]    rd_addr,
	output logic                            busy,
	output logic                            done,
	output logic [pcs_pkg::PIX_BITS-1:0]    dark,
	output logic [pcs_pkg::PIX_BITS-1:0]    bright
);
	import pcs_pkg::*;

	srch_state_t           state_q, state_d;
	logic                  dir_q;
	logic [LIMIT_BITS-1:0] limit_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [BIN_BITS-1:0]   level_q;
	logic [STEP_BITS-1:0]  n_q;
	logic [PIX_BITS-1:0]   dark_q;
	logic [PIX_BITS-1:0]   bright_q;
	logic [COUNT_BITS-1:0] thr;
	logic                  stop;
	logic [MARGIN_BITS-1:0] margin;

	assign thr    = limit_q[LIMIT_BITS-1:MARGIN_BITS];
	assign stop   = n_q[BIN_BITS] || (sum_q > {{BIN_BITS{1'b0}}, thr});
	assign margin = dir_q ? high_margin : low_margin;

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		unique case (state_q)
			SR_IDLE: begin
				if (start) state_d = SR_WRITE;
			end
			SR_WRITE: state_d = SR_MUL;
			SR_MUL:   state_d = SR_RD;
			SR_RD: begin
				if (stop) begin
					state_d = dir_q ? SR_DONE : SR_MUL;
				end else begin
					rd_en   = 1'b1;
					state_d = SR_ADD;
				end
			end
			SR_ADD: state_d = SR_RD;
			SR_DONE: begin
				if (ack) state_d = SR_IDLE;
			end
			default: state_d = SR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= 1'b0;
			dark_q   <= '0;
			bright_q <= PIX_MAX;
		end else begin
			if (state_q == SR_IDLE && start) begin
				dir_q <= 1'b0;
			end
			if (state_q == SR_RD && stop) begin
				if (dir_q) begin
					bright_q <= level_q;
				end else begin
					dark_q <= level_q;
					dir_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SR_MUL) begin
			limit_q <= LIMIT_BITS'(margin) * LIMIT_BITS'(count);
			sum_q   <= '0;
			n_q     <= '0;
			level_q <= dir_q ? PIX_MAX : '0;
		end
		if (state_q == SR_ADD) begin
			sum_q   <= sum_q + SUM_BITS'(rd_count);
			level_q <= dir_q ? level_q - 1'b1 : level_q + 1'b1;
			n_q     <= n_q + 1'b1;
		end
	end

	assign rd_addr = level_q;
	assign busy    = state_q != SR_IDLE;
	assign done    = state_q == SR_DONE;
	assign dark    = dark_q;
	assign bright  = bright_q;

endmodule

>>> rtl/pcs_map.sv
module pcs_map (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_v,
	input  logic [pcs_pkg::PIX_BITS-1:0] pixel,
	input  logic                         last,
	input  logic [pcs_pkg::PIX_BITS-1:0] dark,
	input  logic [pcs_pkg::PIX_BITS-1:0] bright,
	output logic                         out_v,
	output pcs_pkg::out_item_t           out_item,
	output logic                         busy
);
	import pcs_pkg::*;

	logic [PIX_BITS:0]    diff;
	logic [PIX_BITS:0]    den9;
	logic [PIX_BITS-1:0]  diff_abs;
	logic [PIX_BITS-1:0]  den_abs;
	logic [NUM_BITS-1:0]  num;
	logic                 zero;
	logic [QUO_BITS-1:0]  quo;

	logic                 v_s1, v_s2;
	logic [NUM_BITS-1:0]  num_s1;
	logic [PIX_BITS-1:0]  den_s1;
	logic                 zero_s1, zero_s2;
	logic                 last_s1, last_s2;
	logic [PIX_BITS-1:0]  dark_s1, dark_s2;
	logic [PIX_BITS-1:0]  bright_s1, bright_s2;
	logic [PROD_BITS-1:0] prod_s2;

	always_comb begin
		diff     = {1'b0, pixel} - {1'b0, dark};
		den9     = {1'b0, bright} - {1'b0, dark};
		diff_abs = diff[PIX_BITS] ? PIX_BITS'(-diff) : diff[PIX_BITS-1:0];
		den_abs  = den9[PIX_BITS] ? PIX_BITS'(-den9) : den9[PIX_BITS-1:0];
		// times 255
		num      = (NUM_BITS'(diff_abs) << PIX_BITS) - NUM_BITS'(diff_abs);
		// zero divisor, or a negative quotient that clamps to 0
		zero     = (den9 == '0) || ((diff[PIX_BITS] != den9[PIX_BITS]) && (diff != '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1    <= num;
			den_s1    <= den_abs;
			zero_s1   <= zero;
			last_s1   <= last;
			dark_s1   <= dark;
			bright_s1 <= bright;
			prod_s2   <= PROD_BITS'(num_s1) * PROD_BITS'(RECIP[den_s1]);
			zero_s2   <= zero_s1;
			last_s2   <= last_s1;
			dark_s2   <= dark_s1;
			bright_s2 <= bright_s1;
		end
	end

	assign quo = prod_s2[PROD_BITS-1:RECIP_SHIFT];

	always_comb begin
		out_item.result_kind = KIND_PIXEL;
		if (zero_s2) begin
			out_item.mapped_pixel = '0;
		end else if (quo > QUO_BITS'(PIX_MAX)) begin
			out_item.mapped_pixel = PIX_MAX;
		end else begin
			out_item.mapped_pixel = quo[PIX_BITS-1:0];
		end
		out_item.low_bound  = dark_s2;
		out_item.high_bound = bright_s2;
		out_item.pass_end   = last_s2;
	end

	assign out_v = v_s2;
	assign busy  = v_s1 | v_s2;

endmodule

>>> rtl/percentile_contrast_stretch.sv
// Percentile contrast stretch of one 8-bit channel in two passes. Histogram
// pixels (cmd 0) are taken one per cycle while no bound search runs and the
// output is not stalled, and give no beat until the last one, which starts
// the bound search: the histogram memory is walked upward for the dark level
// and downward for the bright level, and no pixel is taken until the bounds
// beat is sent. Mapping pixels (cmd 1) are taken one per cycle under the same
// conditions and come out through a reciprocal-table multiply. The last
// mapping pixel clears the histogram and the pixel count at once.
module percentile_contrast_stretch (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  pcs_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output pcs_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [pcs_pkg::MARGIN_BITS-1:0] cfg_data
);
	import pcs_pkg::*;

	logic [MARGIN_BITS-1:0] low_margin_q;
	logic [MARGIN_BITS-1:0] high_margin_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic                   out_v_q;
	out_item_t              out_q;

	logic                   adv;
	logic                   acc;
	logic                   hist_acc;
	logic                   map_acc;
	logic                   map_last;
	logic                   start;
	logic                   emit;
	logic                   srch_busy;
	logic                   srch_done;
	logic                   srch_rd;
	logic [BIN_BITS-1:0]    srch_addr;
	logic [COUNT_BITS-1:0]  rd_count;
	logic [PIX_BITS-1:0]    dark;
	logic [PIX_BITS-1:0]    bright;
	logic                   map_v;
	logic                   map_busy;
	out_item_t              map_item;
	out_item_t              bounds;

	assign adv      = ~out_v_q | ~out_stall;
	assign in_stall = srch_busy | ~adv;
	assign acc      = in_valid & ~in_stall;
	assign hist_acc = acc & (in_data.cmd == CMD_HIST);
	assign map_acc  = acc & (in_data.cmd == CMD_MAP);
	assign map_last = map_acc & in_data.last;
	assign start    = hist_acc & in_data.last;
	assign emit     = srch_done & ~map_busy & adv;

	pcs_hist u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_v     (hist_acc),
		.upd_bin   (in_data.pixel),
		.clear     (map_last),
		.srch_rd   (srch_rd),
		.srch_addr (srch_addr),
		.rd_count  (rd_count)
	);

	pcs_search u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.ack         (emit),
		.count       (count_q),
		.low_margin  (low_margin_q),
		.high_margin (high_margin_q),
		.rd_count    (rd_count),
		.rd_en       (srch_rd),
		.rd_addr     (srch_addr),
		.busy        (srch_busy),
		.done        (srch_done),
		.dark        (dark),
		.bright      (bright)
	);

	pcs_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (map_acc),
		.pixel    (in_data.pixel),
		.last     (in_data.last),
		.dark     (dark),
		.bright   (bright),
		.out_v    (map_v),
		.out_item (map_item),
		.busy     (map_busy)
	);

	always_comb begin
		bounds.result_kind  = KIND_BOUNDS;
		bounds.mapped_pixel = '0;
		bounds.low_bound    = dark;
		bounds.high_bound   = bright;
		bounds.pass_end     = 1'b1;
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_margin_q  <= MARGIN_RESET;
			high_margin_q <= MARGIN_RESET;
			count_q       <= '0;
			out_v_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_LOW_MARGIN:  low_margin_q  <= cfg_data;
					REG_HIGH_MARGIN: high_margin_q <= cfg_data;
					default: ;
				endcase
			end
			if (map_last) begin
				count_q <= '0;
			end else if (hist_acc && count_q != COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
			if (adv) begin
				out_v_q <= map_v | emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= emit ? bounds : map_item;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> srch_busy)
		else $error("bound search did not start");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		map_last |=> count_q == '0)
		else $error("pixel count not cleared");

	a_bounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == KIND_BOUNDS |-> out_data.pass_end)
		else $error("bounds beat without pass end");

	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid && out_data.result_kind == KIND_BOUNDS)
		else $error("bounds beat lost");

endmodule
